@@ rtl/trd_pkg.sv @@
// Shared types and constants for the touch report decoder.
// Depends on nothing; every other file imports it.
package trd_pkg;

    localparam int REPORT_LENGTH = 25;
    localparam int POS_W = $clog2(REPORT_LENGTH);

    localparam int USED_BYTES = 24;
    localparam int IDX_W = $clog2(USED_BYTES);

    localparam int PRESSED_AT = 1;
    localparam int MASK_AT = 7;

    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W = 3;
    localparam int SLOT_BASE [NUM_SLOTS] = '{2, 8, 12, 16, 20};

    localparam int COORD_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_SYNC  = 2'd2
    } kind_t;

    typedef logic [NUM_SLOTS-1:0][COORD_W-1:0] coord_set_t;

    typedef struct packed {
        logic                 pressed;
        logic [NUM_SLOTS-1:0] mask;
        coord_set_t           x;
        coord_set_t           y;
    } desc_t;

endpackage

@@ rtl/trd_front.sv @@
// Front end: frames incoming bytes into reports and classifies each finished report.
// Depends on trd_pkg; feeds trd_queue.
module trd_front
    import trd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       push,
    output desc_t      push_data
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             touch_active_reg;
    logic             touch_active_next;
    logic [7:0]       bytes_reg [USED_BYTES];
    logic [7:0]       view [USED_BYTES];
    logic             accept;
    logic             last_byte;
    logic             pressed;

    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign last_byte = (pos_reg == POS_W'(REPORT_LENGTH - 1));

    always_comb
    begin
        for (int i = 0; i < USED_BYTES; i++)
        begin
            view[i] = (pos_reg == POS_W'(i)) ? data_byte : bytes_reg[i];
        end
    end

    assign pressed = (view[PRESSED_AT] == 8'd1);

    always_comb
    begin
        push_data.pressed = pressed;
        push_data.mask    = view[MASK_AT][NUM_SLOTS-1:0];
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (s == 0)
            begin
                push_data.x[s] = {view[SLOT_BASE[s]], view[SLOT_BASE[s] + 1]};
                push_data.y[s] = {view[SLOT_BASE[s] + 2], view[SLOT_BASE[s] + 3]};
            end
            else
            begin
                push_data.y[s] = {view[SLOT_BASE[s]], view[SLOT_BASE[s] + 1]};
                push_data.x[s] = {view[SLOT_BASE[s] + 2], view[SLOT_BASE[s] + 3]};
            end
        end
    end

    always_comb
    begin
        pos_next          = pos_reg;
        touch_active_next = touch_active_reg;
        push              = 1'b0;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next          = '0;
                touch_active_next = pressed;
                push              = pressed || touch_active_reg;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            touch_active_reg <= 1'b0;
        end
        else
        begin
            pos_reg          <= pos_next;
            touch_active_reg <= touch_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg < POS_W'(USED_BYTES)))
        begin
            bytes_reg[pos_reg[IDX_W-1:0]] <= data_byte;
        end
    end

endmodule

@@ rtl/trd_queue.sv @@
// Short queue of decoded report descriptors between the front and back ends.
// Depends on trd_pkg.
module trd_queue
    import trd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output desc_t head
);

    desc_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("descriptor pushed into a full queue");

endmodule

@@ rtl/trd_back.sv @@
// Back end: expands one report descriptor into its result beats.
// Depends on trd_pkg; drains trd_queue and drives the output register.
module trd_back
    import trd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  desc_t               q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [SLOT_W-1:0]   slot,
    output logic [COORD_W-1:0]  x_pos,
    output logic [COORD_W-1:0]  y_pos,
    output logic                last
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 empty_pend_reg;
    logic                 empty_pend_next;
    logic [NUM_SLOTS-1:0] mask_reg;
    logic [NUM_SLOTS-1:0] mask_next;
    coord_set_t           x_reg;
    coord_set_t           y_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    kind_t                kind_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [COORD_W-1:0]   x_pos_reg;
    logic [COORD_W-1:0]   y_pos_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 emit;
    kind_t                e_kind;
    logic [SLOT_W-1:0]    e_slot;
    logic [COORD_W-1:0]   e_x;
    logic [COORD_W-1:0]   e_y;
    logic                 e_last;
    logic [SLOT_W-1:0]    sel;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        busy_next       = busy_reg;
        empty_pend_next = empty_pend_reg;
        mask_next       = mask_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        e_kind          = KIND_SYNC;
        e_slot          = '0;
        e_x             = '0;
        e_y             = '0;
        e_last          = 1'b0;
        if (!busy_reg)
        begin
            if (q_valid)
            begin
                q_pop           = 1'b1;
                busy_next       = 1'b1;
                empty_pend_next = !q_head.pressed;
                mask_next       = q_head.pressed ? q_head.mask : '0;
            end
        end
        else if (out_free)
        begin
            emit = 1'b1;
            if (empty_pend_reg)
            begin
                e_kind          = KIND_EMPTY;
                empty_pend_next = 1'b0;
            end
            else if (mask_reg != '0)
            begin
                e_kind    = KIND_POINT;
                e_slot    = sel;
                e_x       = x_reg[sel];
                e_y       = y_reg[sel];
                mask_next = mask_reg & ~(NUM_SLOTS'(1) << sel);
            end
            else
            begin
                e_kind    = KIND_SYNC;
                e_last    = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            empty_pend_reg <= 1'b0;
            mask_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            empty_pend_reg <= empty_pend_next;
            mask_reg       <= mask_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            x_reg <= q_head.x;
            y_reg <= q_head.y;
        end
        if (emit)
        begin
            kind_reg  <= e_kind;
            slot_reg  <= e_slot;
            x_pos_reg <= e_x;
            y_pos_reg <= e_y;
            last_reg  <= e_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign slot      = slot_reg;
    assign x_pos     = x_pos_reg;
    assign y_pos     = y_pos_reg;
    assign last      = last_reg;

    a_point_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_POINT)) |-> !last_reg)
        else $error("contact point beat marked as last of its report");

    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> busy_reg)
        else $error("descriptor popped without starting expansion");

endmodule

@@ rtl/touch_report_decoder.sv @@
// A report's last byte pushes a descriptor into the queue; the back end pops it and registers
// its beats. Throughput: one data byte per cycle unless in_stall is high; the back end loads
// each report, then emits one result beat per cycle unless out_stall is high, at most six beats per report.
// Input stalls only while the two-entry descriptor queue is full.
// Reset clears framing position, touch state, queue and output valid; captured bytes
// are not reset.
module touch_report_decoder
    import trd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [SLOT_W-1:0]   slot,
    output logic [COORD_W-1:0]  x_pos,
    output logic [COORD_W-1:0]  y_pos,
    output logic                last
);

    logic  push;
    desc_t push_data;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    desc_t q_head;

    trd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    trd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    trd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .slot      (slot),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .last      (last)
    );

endmodule
